// File: rtl/core/sgs_pkg.sv
// Shared types, widths and the rounding/saturation helper for the
// Savitzky-Golay smoother. No dependencies.
package sgs_pkg;

  localparam int NUM_CH      = 7;
  localparam int SAMPLE_W    = 16;
  localparam int COEF_W      = 18;
  localparam int IDX_W       = 5;
  localparam int PROD_W      = SAMPLE_W + COEF_W;
  localparam int ACC_W       = 40;   // 34-bit products, up to 31 of them
  localparam int HI_W        = ACC_W - 16;
  localparam int WINDOW_DEF  = 9;
  localparam int LANES_DEF   = 7;
  localparam int S_TDATA_W   = 136;
  localparam int M_TDATA_W   = NUM_CH * SAMPLE_W;

  // tdata bit offsets of the input word
  localparam int IDX_LSB     = 0;
  localparam int COEF_LSB    = IDX_LSB + IDX_W;
  localparam int SAMPLE_LSB  = COEF_LSB + COEF_W;

  localparam int RND_HALF    = 32768;
  localparam int SAT_MAX     = 32767;
  localparam int SAT_MIN     = -32768;

  // tuser codes of the input word
  localparam logic REQ_PUSH  = 1'b0;
  localparam logic REQ_LOAD  = 1'b1;

  typedef struct packed {
    logic shift;      // move every cell one place down the chain
    logic load_new;   // head takes the new vector, else the tail (rotate)
  } chain_ctl_t;

  typedef struct packed {
    logic clear;      // zero the accumulators
    logic mul_en;     // take a product this cycle
  } mac_ctl_t;

  typedef struct packed {
    logic                clip;
    logic [SAMPLE_W-1:0] val;
  } res_t;

  // floor((acc + 2^15) / 2^16), saturated to 16 bits
  function automatic res_t sat_round(input logic signed [ACC_W-1:0] acc);
    logic signed [ACC_W-1:0] t;
    logic signed [HI_W-1:0]  hi;
    res_t                    r;
    t  = acc + ACC_W'(RND_HALF);
    hi = t[ACC_W-1:16];
    r.clip = 1'b0;
    r.val  = hi[SAMPLE_W-1:0];
    if (hi > HI_W'(SAT_MAX)) begin
      r.clip = 1'b1;
      r.val  = 16'h7fff;
    end else if (hi < HI_W'(SAT_MIN)) begin
      r.clip = 1'b1;
      r.val  = 16'h8000;
    end
    return r;
  endfunction

endpackage

// File: rtl/core/sgs_cell.sv
// One window cell: holds one sample vector (all lanes) and passes it on.
// Depends on sgs_pkg.
module sgs_cell #(
  parameter int LANES = sgs_pkg::LANES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             shift_i,
  input  logic [LANES*sgs_pkg::SAMPLE_W-1:0] d_i,
  output logic [LANES*sgs_pkg::SAMPLE_W-1:0] q_o
);

  logic [LANES*sgs_pkg::SAMPLE_W-1:0] vec_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vec_q <= '0;
    end else if (shift_i) begin
      vec_q <= d_i;
    end
  end

  assign q_o = vec_q;

endmodule

// File: rtl/core/sgs_chain.sv
// Sample window as a chain of cells, newest at the head, oldest at the tail.
// Rotating WINDOW times walks the window past the tail, oldest first.
// Depends on sgs_pkg and sgs_cell.
module sgs_chain #(
  parameter int WINDOW = sgs_pkg::WINDOW_DEF,
  parameter int LANES  = sgs_pkg::LANES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  sgs_pkg::chain_ctl_t                ctl_i,
  input  logic [LANES*sgs_pkg::SAMPLE_W-1:0] new_vec_i,
  output logic [LANES*sgs_pkg::SAMPLE_W-1:0] tail_o
);

  logic [LANES*sgs_pkg::SAMPLE_W-1:0] link [WINDOW+1];

  // rotate feeds the tail back into the head
  assign link[0] = ctl_i.load_new ? new_vec_i : link[WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    sgs_cell #(
      .LANES (LANES)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (ctl_i.shift),
      .d_i     (link[i]),
      .q_o     (link[i+1])
    );
  end

  assign tail_o = link[WINDOW];

endmodule

// File: rtl/core/sgs_mac.sv
// Per-lane multiply-accumulate: registered product, then accumulate.
// Depends on sgs_pkg.
module sgs_mac #(
  parameter int LANES = sgs_pkg::LANES_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  sgs_pkg::mac_ctl_t                     ctl_i,
  input  logic [LANES*sgs_pkg::SAMPLE_W-1:0]    sample_i,
  input  logic signed [sgs_pkg::COEF_W-1:0]     tap_i,
  output logic [LANES*sgs_pkg::ACC_W-1:0]       acc_o
);

  logic signed [sgs_pkg::PROD_W-1:0] prod_q [LANES];
  logic signed [sgs_pkg::ACC_W-1:0]  acc_q  [LANES];
  logic                              vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= ctl_i.mul_en;
    end
  end

  for (genvar l = 0; l < LANES; l++) begin : g_lane
    logic signed [sgs_pkg::SAMPLE_W-1:0] smp;
    assign smp = sample_i[l*sgs_pkg::SAMPLE_W +: sgs_pkg::SAMPLE_W];

    always_ff @(posedge clk_i) begin
      if (ctl_i.mul_en) begin
        prod_q[l] <= smp * tap_i;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        acc_q[l] <= '0;
      end else if (ctl_i.clear) begin
        acc_q[l] <= '0;
      end else if (vld_q) begin
        acc_q[l] <= acc_q[l] + sgs_pkg::ACC_W'(prod_q[l]);
      end
    end

    assign acc_o[l*sgs_pkg::ACC_W +: sgs_pkg::ACC_W] = acc_q[l];
  end

endmodule

// File: rtl/core/savitzky_golay_smoother.sv
// Savitzky-Golay smoother, top level: control, tap table and output register.
// Depends on sgs_pkg, sgs_chain, sgs_mac.
//
// A push word (tuser = 0) shifts one vector of LANES Q4.12 samples into the
// window and yields one result word: the window rotates once through the
// cell chain, one tap per cycle, into one multiply-accumulate per lane, then
// state ST_ADD takes the last add and state ST_OUT the rounding/saturation
// into the output register. A coefficient word (tuser = 1) writes one Q2.16
// tap; indexes at or above WINDOW are dropped. s_axis_tready is high only
// between items, so a push occupies the block from acceptance until its
// result is loaded into the output register; the finished result sits there
// and does not hold up the next input word. A previous result still waiting
// there holds the new one, and the input with it, until it is taken. Window
// and taps are zero after reset. Channels at or above LANES read as zero.
module savitzky_golay_smoother #(
  parameter int WINDOW = sgs_pkg::WINDOW_DEF,
  parameter int LANES  = sgs_pkg::LANES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [4:0] coef_index, [22:5] coef_value, [38:23] sample_0 ... [134:119]
  // sample_6, [135] zero
  input  logic [sgs_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] req_type
  input  logic                            s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [15:0] smooth_0, [31:16] smooth_1 ... [111:96] smooth_6
  output logic [sgs_pkg::M_TDATA_W-1:0]   m_axis_tdata,
  // [0] clipped
  output logic                            m_axis_tuser
);

  localparam int KW = $clog2(WINDOW);
  localparam int VW = LANES * sgs_pkg::SAMPLE_W;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_ADD,
    ST_OUT
  } state_e;

  state_e                         state_q;
  logic [KW-1:0]                  k_q;
  logic                           out_valid_q;
  logic [sgs_pkg::M_TDATA_W-1:0]  out_data_q;
  logic                           out_clip_q;
  logic signed [sgs_pkg::COEF_W-1:0] tap_q [WINDOW];

  logic                           s_fire;
  logic                           push_fire;
  logic                           load_fire;
  logic                           out_load;
  logic [sgs_pkg::IDX_W-1:0]      coef_idx;
  logic [VW-1:0]                  new_vec;
  logic [VW-1:0]                  tail_vec;
  logic [LANES*sgs_pkg::ACC_W-1:0] acc_vec;
  logic [sgs_pkg::M_TDATA_W-1:0]  res_data;
  logic [sgs_pkg::NUM_CH-1:0]     res_clip;
  sgs_pkg::chain_ctl_t            chain_ctl;
  sgs_pkg::mac_ctl_t              mac_ctl;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire    = s_axis_tvalid && s_axis_tready;
  assign push_fire = s_fire && (s_axis_tuser == sgs_pkg::REQ_PUSH);
  assign load_fire = s_fire && (s_axis_tuser == sgs_pkg::REQ_LOAD);
  assign coef_idx  = s_axis_tdata[sgs_pkg::IDX_LSB +: sgs_pkg::IDX_W];
  // output register free, or emptied at this same edge
  assign out_load  = (state_q == ST_OUT) && (!out_valid_q || m_axis_tready);

  for (genvar l = 0; l < LANES; l++) begin : g_in
    assign new_vec[l*sgs_pkg::SAMPLE_W +: sgs_pkg::SAMPLE_W] =
      s_axis_tdata[sgs_pkg::SAMPLE_LSB + l*sgs_pkg::SAMPLE_W +: sgs_pkg::SAMPLE_W];
  end

  always_comb begin
    chain_ctl.shift    = push_fire || (state_q == ST_RUN);
    chain_ctl.load_new = (state_q == ST_IDLE);
    mac_ctl.clear      = push_fire;
    mac_ctl.mul_en     = (state_q == ST_RUN);
  end

  sgs_chain #(
    .WINDOW (WINDOW),
    .LANES  (LANES)
  ) u_chain (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (chain_ctl),
    .new_vec_i (new_vec),
    .tail_o    (tail_vec)
  );

  sgs_mac #(
    .LANES (LANES)
  ) u_mac (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (mac_ctl),
    .sample_i (tail_vec),
    .tap_i    (tap_q[k_q]),
    .acc_o    (acc_vec)
  );

  // tap table, zero after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WINDOW; i++) begin
        tap_q[i] <= '0;
      end
    end else if (load_fire && (coef_idx < sgs_pkg::IDX_W'(WINDOW))) begin
      tap_q[coef_idx[KW-1:0]] <= s_axis_tdata[sgs_pkg::COEF_LSB +: sgs_pkg::COEF_W];
    end
  end

  for (genvar c = 0; c < sgs_pkg::NUM_CH; c++) begin : g_res
    if (c < LANES) begin : g_used
      sgs_pkg::res_t r;
      assign r = sgs_pkg::sat_round(acc_vec[c*sgs_pkg::ACC_W +: sgs_pkg::ACC_W]);
      assign res_data[c*sgs_pkg::SAMPLE_W +: sgs_pkg::SAMPLE_W] = r.val;
      assign res_clip[c] = r.clip;
    end else begin : g_unused
      assign res_data[c*sgs_pkg::SAMPLE_W +: sgs_pkg::SAMPLE_W] = '0;
      assign res_clip[c] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_clip_q  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (push_fire) begin
            state_q <= ST_RUN;
            k_q     <= '0;
          end
        end
        ST_RUN: begin
          k_q <= k_q + 1'b1;
          if (k_q == KW'(WINDOW - 1)) begin
            state_q <= ST_ADD;
          end
        end
        ST_ADD: begin
          state_q <= ST_OUT;
        end
        ST_OUT: begin
          if (out_load) begin
            out_data_q  <= res_data;
            out_clip_q  <= |res_clip;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_clip_q;

endmodule
